>>> src/ise_pkg.sv
// shared constants and types for the insertion sort engine
`timescale 1ns / 1ps

package ise_pkg;

  // number of entries the sorted row can hold
  localparam int unsigned CAPACITY = 16;
  // width of the fill count, which must also hold CAPACITY itself
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0] count_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic ins;    // insert the incoming word this cycle
    logic shift;  // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

>>> src/ise_cell.sv
// one cell of the sorted row: holds one entry and trades with its neighbors
`timescale 1ns / 1ps

module ise_cell (
  input  logic              clk_i,
  input  ise_pkg::cell_ctrl_t ctrl_i,
  input  ise_pkg::value_t   new_value_i,
  input  logic              empty_i,
  input  ise_pkg::value_t   left_value_i,
  input  logic              left_gt_i,
  input  ise_pkg::value_t   right_value_i,
  output ise_pkg::value_t   value_o,
  output logic              gt_o
);
  import ise_pkg::*;

  value_t value_q;
  value_t value_d;

  // strictly greater keeps equal entries ahead of the new word
  assign gt_o = empty_i || (value_q > new_value_i);
  assign value_o = value_q;

  // entry update: open a slot on insert, move toward the head on drain
  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
    end else if (ctrl_i.ins && gt_o) begin
      value_d = left_gt_i ? left_value_i : new_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> src/insertion_sort_engine.sv
// top level of the insertion sort engine: cell row, fill count and drain control
`timescale 1ns / 1ps
// Usage:
// A word (sample_value_i, set_end_i) is taken at a rising edge where start is
// high and busy is low. Each word is placed into a row of CAPACITY cells in
// ascending signed order in the cycle it is taken; equal values keep their
// arrival order. Words that arrive while the row is full are dropped and the
// overflow flag of the set is raised.
// A word with set_end_i high is placed like any other and then starts the
// drain: from the next cycle on, one result per cycle leaves the head of the
// row on sorted_value_o with strobe high, smallest first, one for each entry
// the row holds (1 to CAPACITY). run_end_o marks the largest value and
// overflowed_o is the same on every result of the set.
// Throughput: one word per cycle while filling, since the insert is a single
// compare in each cell plus a hand-off to the right neighbor. Busy is high
// while a set drains. The first result appears in the cycle after the
// set_end word is taken.
// Reset clears the fill count, the overflow flag and the drain state; the
// cell contents are not reset. Results cannot be held off by the receiver:
// each one is present for exactly one cycle.
module insertion_sort_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ise_pkg::value_t     sample_value_i,
  input  logic                set_end_i,
  output logic                strobe,
  output ise_pkg::value_t     sorted_value_o,
  output logic                run_end_o,
  output logic                overflowed_o
);
  import ise_pkg::*;

  count_t     count_q, count_d;
  logic       dropped_q, dropped_d;
  logic       drain_q, drain_d;
  logic       accept;
  logic       has_room;
  cell_ctrl_t ctrl;

  value_t cell_value [CAPACITY];
  logic   cell_gt    [CAPACITY+1];

  assign accept   = start && !drain_q;
  assign has_room = count_q < count_t'(CAPACITY);

  assign ctrl.ins   = accept && has_room;
  assign ctrl.shift = drain_q;

  assign cell_gt[0] = 1'b0;

  // the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_v;
    value_t right_v;
    logic   empty;

    if (i == 0) begin : g_head
      assign left_v = sample_value_i;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_value[i];
    end else begin : g_body
      assign right_v = cell_value[i+1];
    end
    assign empty = count_q <= count_t'(i);

    ise_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_value_i  (sample_value_i),
      .empty_i      (empty),
      .left_value_i (left_v),
      .left_gt_i    (cell_gt[i]),
      .right_value_i(right_v),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i+1])
    );
  end

  // fill count, overflow flag and drain control
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    drain_d   = drain_q;
    if (drain_q) begin
      count_d = count_q - count_t'(1);
      if (count_q == count_t'(1)) begin
        drain_d   = 1'b0;
        dropped_d = 1'b0;
      end
    end else if (accept) begin
      if (has_room) begin
        count_d = count_q + count_t'(1);
      end else begin
        dropped_d = 1'b1;
      end
      if (set_end_i) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      drain_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      drain_q   <= drain_d;
    end
  end

  // result ports come straight from the head cell and control registers
  assign busy           = drain_q;
  assign strobe         = drain_q;
  assign sorted_value_o = cell_value[0];
  assign run_end_o      = drain_q && (count_q == count_t'(1));
  assign overflowed_o   = drain_q && dropped_q;

  // a set end word always produces at least one result next cycle
  a_set_end_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && set_end_i) |=> strobe)
    else $error("set end word did not start the drain");

  // the drain keeps going until the marked last result
  a_drain_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && !run_end_o) |=> strobe)
    else $error("drain stopped before the last result");

  // the last result frees the block and clears the fill count and overflow flag
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o |=> (!busy && count_q == '0 && !dropped_q))
    else $error("state not cleared after the last result");

  // the fill count never passes the row length
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(CAPACITY))
    else $error("fill count beyond capacity");

endmodule
